/* src/bss_pkg.sv */
// Shared constants, types and codes for the byte substring search block.
`timescale 1ns / 1ps
`default_nettype none
package bss_pkg;

   localparam int MAX_NEEDLE = 64;
   localparam int LEN_W      = $clog2(MAX_NEEDLE + 1);
   localparam int IDX_W      = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
   localparam int POS_W      = 32;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_NOT_FOUND = 2'd0,
      ST_FOUND     = 2'd1,
      ST_TOO_LONG  = 2'd2
   } status_type;

   // Control for one cell of the shift-and row.
   typedef struct packed {
      logic       load;
      logic       shift;
      logic [7:0] data;
   } cell_ctrl_type;

   // Control for the whole row, driven by the top level.
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_idx;
      logic             shift;
      logic [7:0]       data;
      logic [IDX_W-1:0] sel_idx;
   } row_ctrl_type;

endpackage
`default_nettype wire

/* src/bss_ifs.sv */
// Request and response channel interfaces of the byte substring search block.
`timescale 1ns / 1ps
`default_nettype none
interface bss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface bss_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [bss_pkg::POS_W-1:0] position;

   modport source (output valid, output status, output position, input ready);
   modport sink   (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

/* src/bss_cell.sv */
// One cell: holds a pattern byte and the partial-match flag for its prefix.
`timescale 1ns / 1ps
`default_nettype none
module bss_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bss_pkg::cell_ctrl_type ctrl,
   input  wire logic                   prev_hit,
   output logic                        hit_ff,
   output logic                        hit_in
);
   import bss_pkg::*;

   logic [7:0] pat_ff;

   // hit: the newest text bytes equal the pattern prefix ending at this cell
   always_comb begin
      if (ctrl.shift) begin
         hit_in = prev_hit && (ctrl.data == pat_ff);
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff <= ctrl.data;
      end
   end

endmodule
`default_nettype wire

/* src/bss_row.sv */
// Chain of cells; each hands its match flag to the next on every text byte.
`timescale 1ns / 1ps
`default_nettype none
module bss_row (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bss_pkg::row_ctrl_type ctrl,
   output logic                       hit_next
);
   import bss_pkg::*;

   logic [MAX_NEEDLE-1:0] hit_q;
   logic [MAX_NEEDLE-1:0] hit_d;

   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
      cell_ctrl_type cctrl;
      logic          prev;

      assign cctrl.load  = ctrl.load && (ctrl.load_idx == IDX_W'(i));
      assign cctrl.shift = ctrl.shift;
      assign cctrl.data  = ctrl.data;

      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_body
         assign prev = hit_q[i-1];
      end

      bss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cctrl),
         .prev_hit (prev),
         .hit_ff   (hit_q[i]),
         .hit_in   (hit_d[i])
      );
   end

   // flag of the cell holding the last pattern byte, after this byte
   assign hit_next = hit_d[ctrl.sel_idx];

endmodule
`default_nettype wire

/* src/byte_substring_search.sv */
// Byte substring search: shift-and matcher over a row of pattern cells.
// A finish request's response is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while not stalled; each text byte updates the whole row at once.
// Requests stall only while a response is held and not taken.
// Synchronous reset clears pattern length, overflow, text count, match and
// the response valid flag; pattern bytes and response fields keep their contents.
`timescale 1ns / 1ps
`default_nettype none
module byte_substring_search (
   input  wire logic clock,
   input  wire logic reset,
   bss_req_if.sink   req_ch,
   bss_rsp_if.source rsp_ch
);
   import bss_pkg::*;

   logic [LEN_W-1:0] len_ff,   len_in;
   logic             ovf_ff,   ovf_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             seen_ff,  seen_in;
   logic [POS_W-1:0] offset_ff, offset_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   logic             accept;
   op_type           op;
   logic             hit_next;
   logic             room;
   logic [POS_W-1:0] count_inc;
   logic [LEN_W-1:0] len_m1;
   row_ctrl_type     row_ctrl;

   assign op        = op_type'(req_ch.operation);
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ch.ready;
   assign room      = (len_ff < LEN_W'(MAX_NEEDLE));
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + POS_W'(1);
   assign len_m1    = len_ff - LEN_W'(1);

   always_comb begin
      row_ctrl.load     = accept && (op == OP_APPEND) && room;
      row_ctrl.load_idx = len_ff[IDX_W-1:0];
      row_ctrl.shift    = accept && (op == OP_TEXT);
      row_ctrl.data     = req_ch.data_byte;
      row_ctrl.sel_idx  = len_m1[IDX_W-1:0];
   end

   bss_row u_row (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (row_ctrl),
      .hit_next (hit_next)
   );

   always_comb begin
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      offset_in     = offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (accept) begin
         case (op)
            OP_CLEAR: begin
               len_in    = '0;
               ovf_in    = 1'b0;
               count_in  = '0;
               seen_in   = 1'b0;
               offset_in = '0;
            end
            OP_APPEND: begin
               if (room) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               count_in  = '0;
               seen_in   = 1'b0;
               offset_in = '0;
            end
            OP_TEXT: begin
               count_in = count_inc;
               // need at least len bytes since the last pattern change or finish
               if (!seen_ff && !ovf_ff && (len_ff != '0) &&
                   (count_inc >= POS_W'(len_ff)) && hit_next) begin
                  seen_in   = 1'b1;
                  offset_in = count_inc - POS_W'(len_ff);
               end
            end
            OP_FINISH: begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  rsp_status_in = ST_TOO_LONG;
                  rsp_pos_in    = '0;
               end else if (len_ff == '0) begin
                  rsp_status_in = ST_FOUND;
                  rsp_pos_in    = '0;
               end else if (seen_ff) begin
                  rsp_status_in = ST_FOUND;
                  rsp_pos_in    = offset_ff;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_pos_in    = '0;
               end
               count_in  = '0;
               seen_in   = 1'b0;
               offset_in = '0;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.position = rsp_pos_ff;

endmodule
`default_nettype wire
